[sv/rcpwd_pkg.sv]
// ----------------------------------------------------------------------------
// rcpwd_pkg
// Shared constants, codes and types of the RC pulse width decoder.
// ----------------------------------------------------------------------------
package rcpwd_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int CH_IDX_W     = $clog2(NUM_CHANNELS);
    localparam int FRAC_BITS    = 13;

    // quotient bits needed before saturation decides the result
    localparam int QUO_BITS     = (FRAC_BITS + 1 > 16) ? FRAC_BITS + 1 : 16;
    localparam int QCNT_W       = $clog2(QUO_BITS);
    // (|diff| << (FRAC_BITS+1)) + span/2
    localparam int NUM_W        = 33 + FRAC_BITS;
    localparam int SPAN_W       = 16;

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CH0_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CH0_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CH1_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CH1_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_TH = 3'd4;

    localparam logic [CFG_DATA_W-1:0] RST_CH0_LOW   = 16'd1000;
    localparam logic [CFG_DATA_W-1:0] RST_CH0_HIGH  = 16'd2000;
    localparam logic [CFG_DATA_W-1:0] RST_CH1_LOW   = 16'd1250;
    localparam logic [CFG_DATA_W-1:0] RST_CH1_HIGH  = 16'd1750;
    localparam logic [CFG_DATA_W-1:0] RST_SWITCH_TH = 16'd1500;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 56;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FINISH
    } ctl_state_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_CHECK,
        DV_STEP
    } div_state_t;

    typedef struct packed {
        logic done;
        logic overflow;
    } div_status_t;

endpackage

[sv/rc_pulse_width_decoder.sv]
// ----------------------------------------------------------------------------
// rc_pulse_width_decoder
// Four channel RC receiver pulse width decoder with stick normalization.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries edge events: channel and microsecond timestamp in tdata,
//   rise/fall flags in tuser. Every accepted beat yields exactly one m_* beat
//   with the channel, its latest pulse width, the Q3.13 stick position
//   (channels 0, 1) and the switch bit (channels 2, 3).
//   cfg_* writes the five 16-bit registers; cfg_ready is always high.
//   Write registers only while no event is in flight.
// Timing:
//   Stick channels go from accept to m_tvalid through prepare, divider
//   start, range check, 16 restoring steps at one quotient bit each, the
//   wait step that sees done and the finish step. A quotient that
//   overflows is caught by the range check and skips the restoring steps.
//   Switch channels and empty spans go from prepare to the finish step.
//   One event is in flight at a time; s_tready is high only in the idle
//   step, so the next beat is taken only once the finish step is left.
// Reset:
//   Clears rise stamps and widths to zero and loads register defaults.
// Stall:
//   A new event is accepted while the last result waits in the output
//   register; its result holds in the finish step until m_tready frees it.
// ----------------------------------------------------------------------------
module rc_pulse_width_decoder
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rcpwd_pkg::IN_TDATA_W-1:0]    s_tdata,   // channel[1:0], timestamp_us[33:2]
    input  logic [1:0]                          s_tuser,   // rise_edge[0], fall_edge[1]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rcpwd_pkg::OUT_TDATA_W-1:0]   m_tdata,   // out_channel[1:0],
                                                           // pulse_width_us[33:2],
                                                           // normalized[49:34],
                                                           // switch_on[50]
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rcpwd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rcpwd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import rcpwd_pkg::*;

    localparam int VW = QUO_BITS + 2;
    localparam logic signed [VW-1:0] SAT_MAX = VW'(32767);
    localparam logic signed [VW-1:0] SAT_MIN = -VW'(32768);
    localparam logic signed [VW-1:0] OFFSET  = VW'(1) <<< FRAC_BITS;

    ctl_state_t              state_reg, state_next;

    logic [CFG_DATA_W-1:0]   ch0_low_reg, ch0_high_reg, ch1_low_reg, ch1_high_reg;
    logic [CFG_DATA_W-1:0]   switch_th_reg;

    logic [31:0]             rise_stamp_reg [NUM_CHANNELS];
    logic [31:0]             last_width_reg [NUM_CHANNELS];

    logic [1:0]              ch_reg;
    logic [31:0]             w_reg;
    logic                    axis_reg;
    logic                    neg_reg;
    logic [31:0]             mag_reg;
    logic [SPAN_W-1:0]       den_reg;
    logic                    sw_reg;

    logic                    m_valid_reg;
    logic [OUT_TDATA_W-1:0]  m_data_reg;

    logic                    accept;
    logic                    div_start;
    logic                    out_load;

    logic [1:0]              in_ch;
    logic                    in_rise, in_fall;
    logic [31:0]             in_now;
    logic [CH_IDX_W-1:0]     in_idx;
    logic                    in_present;
    logic [31:0]             base_stamp;
    logic [31:0]             w_new;

    logic                    present;
    logic                    is_stick;
    logic [SPAN_W-1:0]       sel_low, sel_high;
    logic                    span_ok;
    logic                    below_low;
    logic [NUM_W-1:0]        numer;

    div_status_t             div_stat;
    logic [QUO_BITS-1:0]     quotient;
    logic signed [VW-1:0]    q_ext;
    logic signed [VW-1:0]    v_raw;
    logic signed [15:0]      norm_val;

    assign in_ch      = s_tdata[1:0];
    assign in_now     = s_tdata[33:2];
    assign in_rise    = s_tuser[0];
    assign in_fall    = s_tuser[1];
    assign in_idx     = CH_IDX_W'(in_ch);
    assign in_present = 32'(in_ch) < NUM_CHANNELS;
    assign accept     = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;

    // rise is applied before fall within one event
    assign base_stamp = in_rise ? in_now : rise_stamp_reg[in_idx];
    assign w_new      = in_fall ? in_now - base_stamp : last_width_reg[in_idx];

    // ---- sequencer ----
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_tvalid) state_next = ST_PREP;
            ST_PREP:      state_next = (is_stick && span_ok) ? ST_DIV_START : ST_FINISH;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:  if (div_stat.done) state_next = ST_FINISH;
            ST_FINISH:    if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:      s_tready  = 1'b1;
            ST_DIV_START: div_start = 1'b1;
            ST_FINISH:    out_load  = !m_valid_reg || m_tready;
            default:      ;
        endcase
    end

    // ---- preparation of the division operands ----
    assign present  = 32'(ch_reg) < NUM_CHANNELS;
    assign is_stick = present && (ch_reg == 2'd0 || ch_reg == 2'd1);
    assign sel_low  = (ch_reg == 2'd0) ? ch0_low_reg  : ch1_low_reg;
    assign sel_high = (ch_reg == 2'd0) ? ch0_high_reg : ch1_high_reg;
    assign span_ok  = sel_high > sel_low;
    assign below_low = w_reg < {16'd0, sel_low};

    assign numer = NUM_W'({mag_reg, {(FRAC_BITS + 1){1'b0}}}) + NUM_W'(den_reg >> 1);

    rcpwd_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (numer),
        .denom    (den_reg),
        .status   (div_stat),
        .quotient (quotient)
    );

    // ---- signed result with saturation ----
    assign q_ext = VW'({2'b00, quotient});
    assign v_raw = neg_reg ? -q_ext - OFFSET : q_ext - OFFSET;

    always_comb
    begin
        if (!axis_reg)
            norm_val = 16'sd0;
        else if (div_stat.overflow)
            norm_val = neg_reg ? -16'sd32768 : 16'sd32767;
        else if (v_raw > SAT_MAX)
            norm_val = 16'sd32767;
        else if (v_raw < SAT_MIN)
            norm_val = -16'sd32768;
        else
            norm_val = v_raw[15:0];
    end

    // ---- control and state registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            ch0_low_reg   <= RST_CH0_LOW;
            ch0_high_reg  <= RST_CH0_HIGH;
            ch1_low_reg   <= RST_CH1_LOW;
            ch1_high_reg  <= RST_CH1_HIGH;
            switch_th_reg <= RST_SWITCH_TH;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                rise_stamp_reg[i] <= '0;
                last_width_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_CH0_LOW:   ch0_low_reg   <= cfg_data;
                    REG_CH0_HIGH:  ch0_high_reg  <= cfg_data;
                    REG_CH1_LOW:   ch1_low_reg   <= cfg_data;
                    REG_CH1_HIGH:  ch1_high_reg  <= cfg_data;
                    REG_SWITCH_TH: switch_th_reg <= cfg_data;
                    default:       ;
                endcase
            end
            if (accept && in_present)
            begin
                for (int i = 0; i < NUM_CHANNELS; i++)
                begin
                    if (in_idx == CH_IDX_W'(i))
                    begin
                        if (in_rise)
                            rise_stamp_reg[i] <= in_now;
                        last_width_reg[i] <= w_new;
                    end
                end
            end
        end
    end

    // ---- datapath registers ----
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg <= in_ch;
            w_reg  <= in_present ? w_new : 32'd0;
        end
        if (state_reg == ST_PREP)
        begin
            axis_reg <= is_stick && span_ok;
            neg_reg  <= below_low;
            mag_reg  <= below_low ? {16'd0, sel_low} - w_reg : w_reg - {16'd0, sel_low};
            den_reg  <= sel_high - sel_low;
            sw_reg   <= present && !is_stick && (w_reg > {16'd0, switch_th_reg});
        end
        if (out_load)
            m_data_reg <= {5'd0, sw_reg, norm_val, w_reg, ch_reg};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ---- assertions ----
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an event is in flight");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIV_WAIT)
        else $error("divider finished outside the wait step");

    a_load_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_FINISH))
        else $error("result presented without a finish step");

    a_norm_only_stick: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[49:34] != 16'd0 |-> m_tdata[1:0] == 2'd0 || m_tdata[1:0] == 2'd1)
        else $error("stick position on a switch channel");

    a_switch_only_sw: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[50] |-> m_tdata[1:0] != 2'd0 && m_tdata[1:0] != 2'd1)
        else $error("switch bit on a stick channel");

endmodule

[sv/rcpwd_div.sv]
// ----------------------------------------------------------------------------
// rcpwd_div
// Iterative restoring divider, one quotient bit per cycle, with an early
// overflow check when the quotient does not fit in QUO_BITS.
// ----------------------------------------------------------------------------
module rcpwd_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [rcpwd_pkg::NUM_W-1:0]    numer,
    input  logic [rcpwd_pkg::SPAN_W-1:0]   denom,
    output rcpwd_pkg::div_status_t         status,
    output logic [rcpwd_pkg::QUO_BITS-1:0] quotient
);
    import rcpwd_pkg::*;

    div_state_t              state_reg, state_next;
    logic [NUM_W-1:0]        num_reg;
    logic [SPAN_W-1:0]       den_reg;
    logic [SPAN_W-1:0]       rem_reg;
    logic [QUO_BITS-1:0]     quo_reg;
    logic [QCNT_W-1:0]       cnt_reg;
    logic                    done_reg;
    logic                    ovf_reg;

    logic                    load_en;
    logic                    check_en;
    logic                    step_en;
    logic                    too_big;
    logic                    last_step;
    logic [SPAN_W:0]         trial;
    logic                    trial_ge;

    assign too_big   = num_reg >= {{(NUM_W - SPAN_W - QUO_BITS){1'b0}}, den_reg,
                                   {QUO_BITS{1'b0}}};
    assign last_step = cnt_reg == QCNT_W'(QUO_BITS - 1);
    assign trial     = {rem_reg, quo_reg[QUO_BITS-1]};
    assign trial_ge  = trial >= {1'b0, den_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DV_IDLE:  if (start) state_next = DV_CHECK;
            DV_CHECK: state_next = too_big ? DV_IDLE : DV_STEP;
            DV_STEP:  if (last_step) state_next = DV_IDLE;
            default:  state_next = DV_IDLE;
        endcase
    end

    always_comb
    begin
        load_en  = 1'b0;
        check_en = 1'b0;
        step_en  = 1'b0;
        unique case (state_reg)
            DV_IDLE:  load_en  = start;
            DV_CHECK: check_en = 1'b1;
            DV_STEP:  step_en  = 1'b1;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            done_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (check_en && too_big) || (step_en && last_step);
            if (check_en)
            begin
                ovf_reg <= too_big;
                cnt_reg <= '0;
            end
            else if (step_en)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            num_reg <= numer;
            den_reg <= denom;
        end
        if (check_en)
        begin
            rem_reg <= num_reg[QUO_BITS+SPAN_W-1:QUO_BITS];
            quo_reg <= num_reg[QUO_BITS-1:0];
        end
        else if (step_en)
        begin
            rem_reg <= trial_ge ? SPAN_W'(trial - {1'b0, den_reg}) : trial[SPAN_W-1:0];
            quo_reg <= {quo_reg[QUO_BITS-2:0], trial_ge};
        end
    end

    assign status.done     = done_reg;
    assign status.overflow = ovf_reg;
    assign quotient        = quo_reg;

endmodule

[test/tb_rc_pulse_width_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rc_pulse_width_decoder
// Self-checking bench: edge events go in on the s_* stream, results on m_* are
// checked beat by beat against a scoreboard that tracks rise stamps, widths
// and the register file, across several register settings and random stalls.
// ----------------------------------------------------------------------------
module tb_rc_pulse_width_decoder;

    import rcpwd_pkg::*;

    localparam int NUM_REGS      = REG_SWITCH_TH + 1;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 4000;
    localparam int IDLE_PCT      = 27;
    localparam int TAIL_CYCLES   = 50;

    typedef struct packed {
        logic [1:0]         ch;
        logic [31:0]        width;
        logic signed [15:0] norm;
        logic               sw;
    } pulse_result_t;

    class pulse_scoreboard;
        logic [15:0]   cfg_regs [NUM_REGS];
        logic [31:0]   rise_mem [NUM_CHANNELS];
        logic [31:0]   width_mem [NUM_CHANNELS];
        pulse_result_t expected_q [$];
        int unsigned   fail_count;

        function new();
            cfg_regs[REG_CH0_LOW]   = RST_CH0_LOW;
            cfg_regs[REG_CH0_HIGH]  = RST_CH0_HIGH;
            cfg_regs[REG_CH1_LOW]   = RST_CH1_LOW;
            cfg_regs[REG_CH1_HIGH]  = RST_CH1_HIGH;
            cfg_regs[REG_SWITCH_TH] = RST_SWITCH_TH;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                rise_mem[i]  = '0;
                width_mem[i] = '0;
            end
            fail_count = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx <= REG_SWITCH_TH)
                cfg_regs[idx] = val;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // signed position, low -> -1.0, high -> +1.0, distance from low rounded half away from zero
        function logic signed [15:0] stick_position(logic [31:0] w, logic [15:0] lo,
                                                     logic [15:0] hi);
            longint          wide_w;
            longint          wide_lo;
            longint          diff;
            longint          v;
            longint unsigned mag;
            longint unsigned span;
            longint unsigned q;
            if (hi <= lo)
                return '0;
            wide_w  = w;
            wide_lo = lo;
            span    = hi - lo;
            diff    = wide_w - wide_lo;
            mag     = (diff < 0) ? -diff : diff;
            q       = ((mag << (FRAC_BITS + 1)) + span / 2) / span;
            v       = (diff < 0) ? -longint'(q) : longint'(q);
            v       = v - (longint'(1) << FRAC_BITS);
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            return v[15:0];
        endfunction

        function void note_event(logic [1:0] ch, logic rise, logic fall, logic [31:0] ts);
            pulse_result_t r;
            logic [31:0]   w;
            if (rise)
                rise_mem[ch] = ts;
            if (fall)
                width_mem[ch] = ts - rise_mem[ch];
            w       = width_mem[ch];
            r.ch    = ch;
            r.width = w;
            r.norm  = '0;
            r.sw    = 1'b0;
            if (ch == 2'd0)
                r.norm = stick_position(w, cfg_regs[REG_CH0_LOW], cfg_regs[REG_CH0_HIGH]);
            else if (ch == 2'd1)
                r.norm = stick_position(w, cfg_regs[REG_CH1_LOW], cfg_regs[REG_CH1_HIGH]);
            else
                r.sw = (w > {16'd0, cfg_regs[REG_SWITCH_TH]});
            expected_q.push_back(r);
        endfunction

        function void note_failure(string msg);
            fail_count++;
            if (fail_count <= 10)
                $display("%s", msg);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] beat);
            pulse_result_t got;
            pulse_result_t want;
            got.ch    = beat[1:0];
            got.width = beat[33:2];
            got.norm  = beat[49:34];
            got.sw    = beat[50];
            if (expected_q.size() == 0)
            begin
                note_failure($sformatf("unexpected beat: ch %0d width %0d norm %0d sw %0b",
                                       got.ch, got.width, got.norm, got.sw));
                return;
            end
            want = expected_q.pop_front();
            if (got.ch !== want.ch || got.width !== want.width ||
                got.norm !== want.norm || got.sw !== want.sw)
                note_failure($sformatf({"mismatch: exp ch %0d width %0d norm %0d sw %0b, ",
                                        "got ch %0d width %0d norm %0d sw %0b"},
                                       want.ch, want.width, want.norm, want.sw,
                                       got.ch, got.width, got.norm, got.sw));
        endfunction

        function void flush_leftover();
            pulse_result_t r;
            while (expected_q.size() != 0)
            begin
                r = expected_q.pop_front();
                note_failure($sformatf("missing beat: ch %0d width %0d", r.ch, r.width));
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;   // channel[1:0], timestamp_us[33:2]
    logic [1:0]             s_tuser = '0;   // rise_edge[0], fall_edge[1]
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;        // out_channel[1:0], pulse_width_us[33:2],
                                            // normalized[49:34], switch_on[50]
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    pulse_scoreboard sb;
    bit              tx_idle_en = 1'b1;
    bit              rx_idle_en = 1'b1;
    bit              hold_req   = 1'b0;
    int              hold_left  = 0;
    int              stall_cycles = 0;
    logic [31:0]     clock_us;

    rc_pulse_width_decoder dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    task automatic send_event(input logic [1:0] ch, input logic rise, input logic fall,
                              input logic [31:0] ts);
        while (tx_idle_en && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - 34){1'b0}}, ts, ch};
        s_tuser  <= {fall, rise};
        do @(posedge clk); while (!s_tready);
        sb.note_event(ch, rise, fall, ts);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, val);
    endtask

    // block must be drained before this is called
    task automatic apply_config(input logic [15:0] lo0, input logic [15:0] hi0,
                                input logic [15:0] lo1, input logic [15:0] hi1,
                                input logic [15:0] th, input bit stray);
        cfg_write(REG_CH0_LOW, lo0);
        cfg_write(REG_CH0_HIGH, hi0);
        cfg_write(REG_CH1_LOW, lo1);
        cfg_write(REG_CH1_HIGH, hi1);
        if (stray)
            cfg_write(REG_SWITCH_TH + 3'($urandom_range(1, 3)), 16'($urandom()));
        cfg_write(REG_SWITCH_TH, th);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_config();
        logic [15:0] lo0;
        logic [15:0] lo1;
        logic [15:0] hi0;
        logic [15:0] hi1;
        if ($urandom_range(0, 3) == 0)
        begin
            lo0 = 16'($urandom());
            hi0 = 16'($urandom());
            lo1 = 16'($urandom());
            hi1 = 16'($urandom());
        end
        else
        begin
            lo0 = 16'($urandom_range(500, 1500));
            hi0 = lo0 + 16'($urandom_range(1, 1500));
            lo1 = 16'($urandom_range(500, 1500));
            hi1 = lo1 + 16'($urandom_range(1, 1500));
        end
        apply_config(lo0, hi0, lo1, hi1, 16'($urandom_range(0, 65535)), 1'b1);
    endtask

    task automatic tx_stop_and_drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_width();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return $urandom_range(0, 65535);
            default: return $urandom_range(0, 4000);
        endcase
    endfunction

    // mostly rise/fall pairs; the rest are stray, doubled or empty edges
    task automatic run_traffic(input int n_items);
        int          k;
        logic [1:0]  ch;
        logic [31:0] w;
        k = 0;
        while (k < n_items)
        begin
            ch = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 99) < 75)
            begin
                w = pick_width();
                clock_us = clock_us + $urandom_range(1, 30000);
                send_event(ch, 1'b1, 1'b0, clock_us);
                clock_us = clock_us + w;
                send_event(ch, 1'b0, 1'b1, clock_us);
                k += 2;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: send_event(ch, 1'($urandom()), 1'($urandom()), $urandom());
                    1: send_event(ch, 1'b1, 1'b1, clock_us);
                    2: send_event(ch, 1'b0, 1'b0, $urandom());
                    default:
                    begin
                        clock_us = clock_us + pick_width();
                        send_event(ch, 1'b0, 1'b1, clock_us);
                    end
                endcase
                k++;
            end
        end
    endtask

    // receiver: checks beats, random backpressure, one long hold on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !(rx_idle_en && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        sb = new();
        clock_us = 32'hFFA0_0000 + $urandom_range(0, 32'h0010_0000);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values of the registers
        send_event(2'd3, 1'b0, 1'b1, 32'd2000);             // fall with no rise yet
        send_event(2'd0, 1'b1, 1'b0, 32'd10000);
        send_event(2'd0, 1'b0, 1'b1, 32'd11500);            // center
        send_event(2'd0, 1'b1, 1'b0, 32'd20000);
        send_event(2'd0, 1'b0, 1'b1, 32'd21000);            // at low
        send_event(2'd0, 1'b1, 1'b0, 32'd30000);
        send_event(2'd0, 1'b0, 1'b1, 32'd32000);            // at high
        send_event(2'd0, 1'b1, 1'b1, 32'd40000);            // rise+fall together
        send_event(2'd0, 1'b0, 1'b0, 32'd50000);            // no edge
        send_event(2'd1, 1'b1, 1'b0, 32'hFFFF_FF00);
        send_event(2'd1, 1'b0, 1'b1, 32'h0000_05DC);        // timestamp wrap
        send_event(2'd1, 1'b1, 1'b0, 32'd0);
        send_event(2'd1, 1'b0, 1'b1, 32'hFFFF_FFFF);        // saturate high
        send_event(2'd2, 1'b1, 1'b0, 32'd100);
        send_event(2'd2, 1'b0, 1'b1, 32'd1600);             // equal to threshold
        send_event(2'd2, 1'b1, 1'b0, 32'd5000);
        send_event(2'd2, 1'b0, 1'b1, 32'd6501);             // one above
        send_event(2'd3, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send_event(2'd3, 1'b0, 1'b0, 32'd0);
        run_traffic(100);
        tx_stop_and_drain();

        // narrow span, reversed span, top threshold
        apply_config(16'd1000, 16'd1001, 16'hFFFF, 16'd0, 16'hFFFF, 1'b0);
        send_event(2'd0, 1'b1, 1'b1, 32'd0);                // saturate low
        send_event(2'd1, 1'b0, 1'b0, 32'd0);                // empty span
        send_event(2'd2, 1'b1, 1'b0, 32'd0);
        send_event(2'd2, 1'b0, 1'b1, 32'd65536);
        run_traffic(80);
        tx_stop_and_drain();

        // full span, equal bounds, zero threshold
        apply_config(16'd0, 16'hFFFF, 16'd3000, 16'd3000, 16'd0, 1'b0);
        run_traffic(80);
        tx_stop_and_drain();

        repeat (4)
        begin
            random_config();
            run_traffic(80);
            tx_stop_and_drain();
        end

        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        random_config();
        run_traffic(100);
        tx_stop_and_drain();

        // receiver stalls long while the sender keeps offering
        rx_idle_en = 1'b1;
        apply_config(RST_CH0_LOW, RST_CH0_HIGH, RST_CH1_LOW, RST_CH1_HIGH,
                     RST_SWITCH_TH, 1'b0);
        hold_req = 1'b1;
        run_traffic(100);
        tx_idle_en = 1'b1;
        tx_stop_and_drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        sb.flush_leftover();
        if (sb.fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
